// ===== rtl/core/ntlmh_pkg.sv =====
// Package: shared constants, types and index functions for the NTLM password hash block.
package ntlmh_pkg;

  // MD4 initial chaining values and round constants
  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [31:0] K2   = 32'h5a827999;
  localparam logic [31:0] K3   = 32'h6ed9eba1;

  // Padding marks for a pad on the low or the high code unit of a word
  localparam logic [31:0] PAD_LO = 32'h00000080;
  localparam logic [31:0] PAD_HI = 32'h00800000;

  // Block geometry
  localparam int unsigned MAX_CHARS   = 27;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned LEN_WORD    = 14;
  localparam int unsigned NUM_STEPS   = 48;

  localparam logic [4:0] MAX_CHARS_C = 5'(MAX_CHARS);
  localparam logic [5:0] LAST_STEP   = 6'(NUM_STEPS - 1);
  localparam logic [3:0] LEN_IDX     = 4'(LEN_WORD);

  // MD4 round codes
  localparam logic [1:0] RND_F = 2'd0;
  localparam logic [1:0] RND_G = 2'd1;
  localparam logic [1:0] RND_H = 2'd2;

  // Sequencer states of the top level
  typedef enum logic [1:0] {
    ST_LOAD,
    ST_PAD,
    ST_HASH,
    ST_FINISH
  } state_t;

  // Status from the step unit back to the sequencer
  typedef struct packed {
    logic busy;
    logic last_step;
  } core_status_t;

  // Message word used by a given step
  function automatic logic [3:0] msg_index(input logic [5:0] step);
    logic [3:0] j;
    logic [3:0] idx;
    j = step[3:0];
    case (step[5:4])
      RND_F:   idx = j;
      RND_G:   idx = {j[1:0], j[3:2]};
      default: idx = {j[0], j[1], j[2], j[3]};
    endcase
    return idx;
  endfunction

  // Left rotation used by a given step
  function automatic logic [4:0] shift_amt(input logic [5:0] step);
    logic [4:0] s;
    case (step[5:4])
      RND_F: begin
        case (step[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd7;
          2'd2:    s = 5'd11;
          default: s = 5'd19;
        endcase
      end
      RND_G: begin
        case (step[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd5;
          2'd2:    s = 5'd9;
          default: s = 5'd13;
        endcase
      end
      default: begin
        case (step[1:0])
          2'd0:    s = 5'd3;
          2'd1:    s = 5'd9;
          2'd2:    s = 5'd11;
          default: s = 5'd15;
        endcase
      end
    endcase
    return s;
  endfunction

  function automatic logic [31:0] rotl32(input logic [31:0] x, input logic [4:0] s);
    logic [63:0] t;
    t = {x, x} << s;
    return t[63:32];
  endfunction

endpackage

// ===== rtl/core/ntlmh_if.sv =====
// Interfaces: password character channel and digest channel.
interface ntlmh_pwd_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       last;

  modport source (output valid, output char_code, output has_char, output last, input ready);
  modport sink   (input valid, input char_code, input has_char, input last, output ready);
endinterface

interface ntlmh_hash_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word0;
  logic [31:0] digest_word1;
  logic [31:0] digest_word2;
  logic [31:0] digest_word3;
  logic        too_long;

  modport source (output valid, output digest_word0, output digest_word1,
                  output digest_word2, output digest_word3, output too_long, input ready);
  modport sink   (input valid, input digest_word0, input digest_word1,
                  input digest_word2, input digest_word3, input too_long, output ready);
endinterface

// ===== rtl/core/ntlmh_md4_core.sv =====
// MD4 step unit: working registers, step counter and one shared step datapath.
module ntlmh_md4_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [31:0]           msg_word,
  output logic [3:0]            msg_idx,
  output ntlmh_pkg::core_status_t status,
  output logic [31:0]           digest0,
  output logic [31:0]           digest1,
  output logic [31:0]           digest2,
  output logic [31:0]           digest3
);
  import ntlmh_pkg::*;

  logic [31:0] work_a, work_b, work_c, work_d;
  logic [5:0]  step;
  logic        busy;
  logic [31:0] f, k, sum;

  assign msg_idx = msg_index(step);

  // Round function and constant for the current step
  always_comb begin
    case (step[5:4])
      RND_F: begin
        f = work_d ^ (work_b & (work_c ^ work_d));
        k = '0;
      end
      RND_G: begin
        f = (work_b & (work_c | work_d)) | (work_c & work_d);
        k = K2;
      end
      default: begin
        f = work_b ^ work_c ^ work_d;
        k = K3;
      end
    endcase
    sum = work_a + f + msg_word + k;
  end

  // Step counter and busy flag
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= '0;
    end else if (busy) begin
      if (step == LAST_STEP) begin
        busy <= 1'b0;
        step <= '0;
      end else begin
        step <= step + 6'd1;
      end
    end
  end

  // Working words: load chaining values, then one step a cycle with role rotation
  always_ff @(posedge clk) begin
    if (rst || start) begin
      work_a <= IV_A;
      work_b <= IV_B;
      work_c <= IV_C;
      work_d <= IV_D;
    end else if (busy) begin
      work_a <= work_d;
      work_b <= rotl32(sum, shift_amt(step));
      work_c <= work_b;
      work_d <= work_c;
    end
  end

  assign status = '{busy: busy, last_step: busy && (step == LAST_STEP)};

  // Feed-forward of the chaining values
  assign digest0 = work_a + IV_A;
  assign digest1 = work_b + IV_B;
  assign digest2 = work_c + IV_C;
  assign digest3 = work_d + IV_D;

endmodule

// ===== rtl/core/ntlm_password_hash.sv =====
// Top level: NTLM password hash, message block packing, sequencer and digest output register.
//
// A password enters one character word per cycle while the block is loading. The word
// marked last is followed by a padding state, the 48 MD4 steps in the single step unit
// (one step per cycle) and a finishing state that moves the digest into the output
// register once that register is free. The input is not ready during padding, hashing
// and finishing. The digest register lets the next password load while a digest waits
// to be taken; only a second digest stalls until the first one has gone.
// Characters past the 27th are dropped and flagged with too_long.
module ntlm_password_hash (
  input  logic          clk,
  input  logic          rst,
  ntlmh_pwd_if.sink     pwd,
  ntlmh_hash_if.source  hash
);
  import ntlmh_pkg::*;

  state_t       state, state_next;
  logic [31:0]  msg [BLOCK_WORDS];
  logic [4:0]   char_count;
  logic         overflow_seen;
  logic         take;
  logic         store;
  logic         core_start;
  logic         unload;
  logic [3:0]   core_idx;
  logic [31:0]  core_word;
  core_status_t core_status;
  logic [31:0]  dg0, dg1, dg2, dg3;

  assign pwd.ready = (state == ST_LOAD);
  assign take      = pwd.valid && pwd.ready;
  assign store     = take && pwd.has_char && (char_count < MAX_CHARS_C);
  assign unload    = (state == ST_FINISH) && (!hash.valid || hash.ready);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    core_start = 1'b0;
    case (state)
      ST_LOAD: begin
        if (take && pwd.last) state_next = ST_PAD;
      end
      ST_PAD: begin
        core_start = 1'b1;
        state_next = ST_HASH;
      end
      ST_HASH: begin
        if (core_status.last_step) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (unload) state_next = ST_LOAD;
      end
      default: state_next = ST_LOAD;
    endcase
  end

  // Character count and overflow flag
  always_ff @(posedge clk) begin
    if (rst || unload) begin
      char_count    <= '0;
      overflow_seen <= 1'b0;
    end else if (take && pwd.has_char) begin
      if (store) char_count <= char_count + 5'd1;
      else       overflow_seen <= 1'b1;
    end
  end

  // Message block: pack code units, then pad and length, cleared once the digest is out
  always_ff @(posedge clk) begin
    if (rst || unload) begin
      for (int i = 0; i < BLOCK_WORDS; i++) msg[i] <= '0;
    end else if (store) begin
      if (char_count[0]) msg[char_count[4:1]][23:16] <= pwd.char_code;
      else               msg[char_count[4:1]][7:0]   <= pwd.char_code;
    end else if (state == ST_PAD) begin
      msg[char_count[4:1]] <= msg[char_count[4:1]] | (char_count[0] ? PAD_HI : PAD_LO);
      msg[LEN_IDX]         <= {23'd0, char_count, 4'd0};
    end
  end

  assign core_word = msg[core_idx];

  ntlmh_md4_core u_core (
    .clk      (clk),
    .rst      (rst),
    .start    (core_start),
    .msg_word (core_word),
    .msg_idx  (core_idx),
    .status   (core_status),
    .digest0  (dg0),
    .digest1  (dg1),
    .digest2  (dg2),
    .digest3  (dg3)
  );

  // Digest output register
  always_ff @(posedge clk) begin
    if (rst) begin
      hash.valid <= 1'b0;
    end else if (unload) begin
      hash.valid <= 1'b1;
    end else if (hash.ready) begin
      hash.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (unload) begin
      hash.digest_word0 <= dg0;
      hash.digest_word1 <= dg1;
      hash.digest_word2 <= dg2;
      hash.digest_word3 <= dg3;
      hash.too_long     <= overflow_seen;
    end
  end

  // The step unit runs only while the sequencer is hashing
  a_busy_in_hash: assert property (@(posedge clk) disable iff (rst)
    core_status.busy |-> (state == ST_HASH))
    else $error("step unit busy outside hashing");

  // A new digest appears only from the finishing cycle
  a_valid_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(hash.valid) |-> $past(state == ST_FINISH))
    else $error("digest raised without a finished hash");

  // The block is cleared for the next password once a digest is unloaded
  a_clear_after_unload: assert property (@(posedge clk) disable iff (rst)
    unload |=> (char_count == 5'd0) && !overflow_seen && (msg[LEN_IDX] == 32'd0))
    else $error("message state not cleared after digest");

endmodule
